### hdl/ssd_pkg.sv
// Shared constants, item codes and the queued command type of the sorted id set.
`default_nettype none
package ssd_pkg;

	localparam int MAX_IDS     = 16;
	localparam int ID_BITS     = 16;
	localparam int CNT_W       = $clog2(MAX_IDS + 1);
	localparam int TYPE_ID_W   = 16;
	localparam int SET_COUNT_W = 5;
	localparam int FUNC_W      = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ELEM  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_CLEAR,
		OP_ELEM,
		OP_EMPTY
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [ID_BITS-1:0] id;
		logic               ends_query;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/ssd_front.sv
// Front end: takes items, decodes them into commands and holds them in a two-entry queue.
`default_nettype none
module ssd_front
	import ssd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [FUNC_W-1:0]    func,
	input  wire logic [TYPE_ID_W-1:0] type_id,
	input  wire logic                 last,
	output logic                      busy,
	output logic                      cmd_valid,
	output cmd_t                      cmd,
	input  wire logic                 cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       dec;

	always_comb begin
		dec.id         = type_id[ID_BITS-1:0];
		dec.op         = OP_ADD;
		dec.ends_query = 1'b0;
		case (func)
			FUNC_ADD: begin
				dec.op = OP_ADD;
			end
			FUNC_CLEAR: begin
				dec.op = OP_CLEAR;
			end
			FUNC_ELEM: begin
				dec.op         = OP_ELEM;
				dec.ends_query = last;
			end
			FUNC_EMPTY: begin
				dec.op         = OP_EMPTY;
				dec.ends_query = 1'b1;
			end
			default: begin
				dec.op = OP_ADD;
			end
		endcase
	end

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/ssd_back.sv
// Back end: the ordered row of id cells, the query accumulators and the result register.
`default_nettype none
module ssd_back
	import ssd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	input  wire cmd_t                   cmd,
	output logic                        cmd_pop,
	output logic                        valid,
	output logic [SET_COUNT_W-1:0]      set_count,
	output logic                        added,
	output logic                        rejected_full,
	output logic                        contains_all,
	output logic                        shares_none,
	output logic                        query_done
);

	logic [ID_BITS-1:0] ent_q [MAX_IDS];
	logic [ID_BITS-1:0] ent_nxt [MAX_IDS];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               all_q;
	logic               none_q;
	logic [MAX_IDS-1:0] eq;
	logic [MAX_IDS-1:0] lt;
	logic               hit;
	logic               is_full;
	logic               do_ins;
	logic               rej;
	logic               all_upd;
	logic               none_upd;

	logic                   valid_q;
	logic [SET_COUNT_W-1:0] set_count_q;
	logic                   added_q;
	logic                   rejected_q;
	logic                   with_q;
	logic                   without_q;
	logic                   done_q;

	// The back end never stalls, so it takes a command whenever one waits.
	assign cmd_pop = cmd_valid;

	// Every cell compares against the id at once; cells below the fill are live.
	always_comb begin
		for (int i = 0; i < MAX_IDS; i++) begin
			eq[i] = (CNT_W'(i) < count_q) && (ent_q[i] == cmd.id);
			lt[i] = (CNT_W'(i) < count_q) && (ent_q[i] < cmd.id);
		end
		// A cell keeps its id if smaller, takes the new id at the insert point,
		// and otherwise takes its lower neighbour's id.
		ent_nxt[0] = lt[0] ? ent_q[0] : cmd.id;
		for (int i = 1; i < MAX_IDS; i++) begin
			if (lt[i]) begin
				ent_nxt[i] = ent_q[i];
			end else if (lt[i-1]) begin
				ent_nxt[i] = cmd.id;
			end else begin
				ent_nxt[i] = ent_q[i-1];
			end
		end
	end

	assign hit     = |eq;
	assign is_full = (count_q == CNT_W'(MAX_IDS));
	assign do_ins  = cmd_valid && (cmd.op == OP_ADD) && !hit && !is_full;
	assign rej     = cmd_valid && (cmd.op == OP_ADD) && !hit && is_full;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd_valid && (cmd.op == OP_CLEAR)) begin
			count_nxt = '0;
		end
	end

	assign all_upd  = all_q && hit;
	assign none_upd = none_q && !hit;

	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int i = 0; i < MAX_IDS; i++) begin
				ent_q[i] <= ent_nxt[i];
			end
		end
		set_count_q  <= SET_COUNT_W'(count_nxt);
		added_q      <= do_ins;
		rejected_q   <= rej;
		if (cmd.op == OP_EMPTY) begin
			with_q    <= 1'b1;
			without_q <= 1'b1;
			done_q    <= 1'b1;
		end else if ((cmd.op == OP_ELEM) && cmd.ends_query) begin
			with_q    <= all_upd;
			without_q <= none_upd;
			done_q    <= 1'b1;
		end else begin
			with_q    <= 1'b0;
			without_q <= 1'b0;
			done_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			all_q   <= 1'b1;
			none_q  <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd_valid;
			count_q <= count_nxt;
			if (cmd_valid) begin
				if (cmd.ends_query) begin
					all_q  <= 1'b1;
					none_q <= 1'b1;
				end else if (cmd.op == OP_ELEM) begin
					all_q  <= all_upd;
					none_q <= none_upd;
				end
			end
		end
	end

	assign valid         = valid_q;
	assign set_count     = set_count_q;
	assign added         = added_q;
	assign rejected_full = rejected_q;
	assign contains_all  = with_q;
	assign shares_none   = without_q;
	assign query_done    = done_q;

endmodule
`default_nettype wire

### hdl/sorted_id_set_subset_disjoint.sv
// Top level of the sorted id set with subset and disjoint queries.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------------
//   item in   start high, busy low func, type_id, last
//   result    valid (one cycle)    set_count, added, rejected_full, contains_all,
//                                  shares_none, query_done
//
// Each item gives one result; valid rises once the item has passed through a queue slot and the result register.
// The back end handles one item per cycle against all sixteen cells in parallel,
// so the sustained rate is one item per cycle.
// Reset empties the set and sets both query accumulators; the stored ids are not cleared.
// The receiver cannot stall and the back end pops whenever a command waits, so the queue never
// holds more than one item and busy stays low.
`default_nettype none
module sorted_id_set_subset_disjoint
	import ssd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [FUNC_W-1:0]      func,
	input  wire logic [TYPE_ID_W-1:0]   type_id,
	input  wire logic                   last,
	output logic                        valid,
	output logic [SET_COUNT_W-1:0]      set_count,
	output logic                        added,
	output logic                        rejected_full,
	output logic                        contains_all,
	output logic                        shares_none,
	output logic                        query_done
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	ssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.type_id   (type_id),
		.last      (last),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ssd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.valid         (valid),
		.set_count     (set_count),
		.added         (added),
		.rejected_full (rejected_full),
		.contains_all  (contains_all),
		.shares_none   (shares_none),
		.query_done    (query_done)
	);

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the sorted id set with subset and disjoint queries.
module tb_top;
	import ssd_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 600;
	localparam int POOL_SIZE    = 24;

	typedef struct packed {
		logic [FUNC_W-1:0]    f;
		logic [TYPE_ID_W-1:0] id;
		logic                 lst;
	} stim_t;

	typedef struct packed {
		logic [SET_COUNT_W-1:0] set_count;
		logic                   added;
		logic                   rejected_full;
		logic                   contains_all;
		logic                   shares_none;
		logic                   query_done;
	} result_t;

	class subset_scoreboard;
		logic [ID_BITS-1:0] members[MAX_IDS];
		int                 n_members;
		bit                 all_hit;
		bit                 none_hit;
		result_t            expected_results[$];
		int                 mismatch_count;

		function new();
			n_members      = 0;
			all_hit        = 1'b1;
			none_hit       = 1'b1;
			mismatch_count = 0;
		endfunction

		task report(string what);
			$display("[%0t] %s", $time, what);
			mismatch_count++;
		endtask

		// Insertion order never shows on an output, so members are simply appended.
		function void note_item(logic [FUNC_W-1:0] f, logic [TYPE_ID_W-1:0] tid, logic lst);
			logic [ID_BITS-1:0] key;
			bit                 hit;
			result_t            r;
			key = tid[ID_BITS-1:0];
			hit = 1'b0;
			for (int i = 0; i < n_members; i++)
				if (members[i] == key)
					hit = 1'b1;
			r = '0;
			case (f)
			FUNC_ADD: begin
				if (!hit) begin
					if (n_members >= MAX_IDS) begin
						r.rejected_full = 1'b1;
					end else begin
						members[n_members] = key;
						n_members++;
						r.added = 1'b1;
					end
				end
			end
			FUNC_CLEAR: begin
				n_members = 0;
			end
			FUNC_ELEM: begin
				if (hit)
					none_hit = 1'b0;
				else
					all_hit = 1'b0;
				if (lst) begin
					r.contains_all = all_hit;
					r.shares_none  = none_hit;
					r.query_done   = 1'b1;
					all_hit        = 1'b1;
					none_hit       = 1'b1;
				end
			end
			default: begin
				r.contains_all = 1'b1;
				r.shares_none  = 1'b1;
				r.query_done   = 1'b1;
				all_hit        = 1'b1;
				none_hit       = 1'b1;
			end
			endcase
			r.set_count = n_members[SET_COUNT_W-1:0];
			expected_results.push_back(r);
		endfunction

		task check_result(logic [SET_COUNT_W-1:0] cnt, logic add_g, logic rej_g,
			logic all_g, logic none_g, logic done_g);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result with no item outstanding (set_count %0d)", cnt));
				return;
			end
			want = expected_results.pop_front();
			if (cnt !== want.set_count)
				report($sformatf("set_count %0d, expected %0d", cnt, want.set_count));
			if (add_g !== want.added)
				report($sformatf("added %b, expected %b", add_g, want.added));
			if (rej_g !== want.rejected_full)
				report($sformatf("rejected_full %b, expected %b", rej_g, want.rejected_full));
			if (all_g !== want.contains_all)
				report($sformatf("contains_all %b, expected %b", all_g, want.contains_all));
			if (none_g !== want.shares_none)
				report($sformatf("shares_none %b, expected %b", none_g, want.shares_none));
			if (done_g !== want.query_done)
				report($sformatf("query_done %b, expected %b", done_g, want.query_done));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [FUNC_W-1:0]      func = FUNC_ADD;
	logic [TYPE_ID_W-1:0]   type_id = '0;
	logic                   last = 1'b0;
	logic                   busy;
	logic                   valid;
	logic [SET_COUNT_W-1:0] set_count;
	logic                   added;
	logic                   rejected_full;
	logic                   contains_all;
	logic                   shares_none;
	logic                   query_done;

	subset_scoreboard       board;
	stim_t                  stim_q[$];
	logic [TYPE_ID_W-1:0]   gen_members[$];
	logic [TYPE_ID_W-1:0]   id_pool[POOL_SIZE];
	int                     cycle_count = 0;

	sorted_id_set_subset_disjoint dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.type_id      (type_id),
		.last         (last),
		.valid        (valid),
		.set_count    (set_count),
		.added        (added),
		.rejected_full(rejected_full),
		.contains_all (contains_all),
		.shares_none  (shares_none),
		.query_done   (query_done)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The generator keeps its own view of the membership so that queries can aim at stored ids.
	function automatic void push_item(logic [FUNC_W-1:0] f, logic [TYPE_ID_W-1:0] tid, logic lst);
		bit present;
		stim_q.push_back('{f, tid, lst});
		if (f == FUNC_CLEAR) begin
			gen_members.delete();
		end else if (f == FUNC_ADD) begin
			present = 1'b0;
			foreach (gen_members[i])
				if (gen_members[i] == tid)
					present = 1'b1;
			if (!present && gen_members.size() < MAX_IDS)
				gen_members.push_back(tid);
		end
	endfunction

	function automatic logic [TYPE_ID_W-1:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return TYPE_ID_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [TYPE_ID_W-1:0] pick_member();
		if (gen_members.size() == 0)
			return pick_id();
		return gen_members[$urandom_range(0, gen_members.size() - 1)];
	endfunction

	function automatic void build_stimulus();
		int                   base;
		int                   choice;
		int                   n;
		int                   mode;
		logic [TYPE_ID_W-1:0] qid;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		id_pool[2] = 16'h8000;
		id_pool[3] = 16'h0001;
		for (int i = 4; i < POOL_SIZE; i++)
			id_pool[i] = TYPE_ID_W'($urandom_range(0, 65535));

		// Directed opening: extremes, duplicates, abandoned and interleaved queries.
		push_item(FUNC_ELEM,  16'h0000, 1'b1);
		push_item(FUNC_EMPTY, 16'h0000, 1'b0);
		push_item(FUNC_ADD,   16'hFFFF, 1'b0);
		push_item(FUNC_ADD,   16'h0000, 1'b1);
		push_item(FUNC_ADD,   16'h8000, 1'b0);
		push_item(FUNC_ADD,   16'h0000, 1'b0);
		push_item(FUNC_ELEM,  16'h0000, 1'b0);
		push_item(FUNC_ELEM,  16'hFFFF, 1'b1);
		push_item(FUNC_ELEM,  16'h0000, 1'b0);
		push_item(FUNC_ELEM,  16'h1234, 1'b1);
		push_item(FUNC_ELEM,  16'h5555, 1'b0);
		push_item(FUNC_ELEM,  16'hAAAA, 1'b1);
		push_item(FUNC_ELEM,  16'h1234, 1'b0);
		push_item(FUNC_EMPTY, 16'hFFFF, 1'b1);
		push_item(FUNC_ELEM,  16'h1234, 1'b0);
		push_item(FUNC_ADD,   16'h1234, 1'b0);
		push_item(FUNC_ELEM,  16'h1234, 1'b0);
		push_item(FUNC_ELEM,  16'h1234, 1'b1);
		push_item(FUNC_CLEAR, 16'h5555, 1'b1);
		push_item(FUNC_ELEM,  16'hFFFF, 1'b1);
		push_item(FUNC_ADD,   16'h7FFF, 1'b1);
		push_item(FUNC_EMPTY, 16'hAAAA, 1'b0);

		base = stim_q.size();
		while (stim_q.size() < base + RANDOM_ITEMS) begin
			choice = $urandom_range(0, 99);
			if (choice < 30) begin
				n = $urandom_range(1, 5);
				for (int k = 0; k < n; k++)
					push_item(FUNC_ADD, pick_id(), 1'($urandom_range(0, 1)));
			end else if (choice < 65) begin
				n = $urandom_range(1, 5);
				mode = $urandom_range(0, 3);
				for (int k = 0; k < n; k++) begin
					// Now and then a query is broken off or the set changes under it.
					if (k > 0 && $urandom_range(0, 19) == 0) begin
						if ($urandom_range(0, 1)) begin
							push_item(FUNC_EMPTY, pick_id(), 1'($urandom_range(0, 1)));
							break;
						end
						push_item(FUNC_ADD, pick_id(), 1'b0);
					end
					case (mode)
					0: qid = pick_member();
					1: qid = pick_id();
					2: qid = $urandom_range(0, 1) ? pick_member() : pick_id();
					default: qid = TYPE_ID_W'($urandom_range(0, 65535));
					endcase
					push_item(FUNC_ELEM, qid, k == n - 1);
				end
			end else if (choice < 75) begin
				push_item(FUNC_EMPTY, pick_id(), 1'($urandom_range(0, 1)));
			end else if (choice < 79) begin
				push_item(FUNC_CLEAR, pick_id(), 1'($urandom_range(0, 1)));
			end else begin
				push_item(FUNC_W'($urandom_range(0, 3)),
					$urandom_range(0, 1) ? pick_id() : TYPE_ID_W'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
			end
		end
	endfunction

	// Items go out in bursts of random length separated by random gaps.
	task automatic drive_items();
		int    next_idx;
		int    burst_left;
		int    gap_left;
		bit    presenting;
		stim_t s;
		next_idx   = 0;
		burst_left = $urandom_range(1, 16);
		gap_left   = 0;
		presenting = 1'b0;
		while (next_idx < stim_q.size() || presenting) begin
			@(posedge clk);
			if (presenting && !busy) begin
				board.note_item(func, type_id, last);
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (next_idx < stim_q.size()) begin
					s = stim_q[next_idx];
					next_idx++;
					func       <= s.f;
					type_id    <= s.id;
					last       <= s.lst;
					presenting = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
						gap_left   = $urandom_range(1, 6);
					end
				end
				start <= presenting;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid)
			board.check_result(set_count, added, rejected_full, contains_all, shares_none,
				query_done);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		board = new();
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		drive_items();
		while (board.expected_results.size() != 0)
			@(posedge clk);
		// Let the clock run on so that any stray result is caught.
		repeat (6) @(posedge clk);
		if (board.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hdl/ssd_pkg.sv
hdl/ssd_front.sv
hdl/ssd_back.sv
hdl/sorted_id_set_subset_disjoint.sv
dv/tb_top.sv
